// File: rtl/core/dta_pkg.sv
// Shared types and constants for the descriptor table allocator.
package dta_pkg;

   localparam int TableDepth  = 64;
   localparam int IdxW        = $clog2(TableDepth);
   localparam int SizeW       = 7;
   localparam int HintW       = 7;
   localparam int ReservedBit = 31;
   localparam logic [SizeW-1:0] SizeAtReset = 7'd16;

   typedef enum logic [2:0] {
      FUNC_ALLOC   = 3'd0,
      FUNC_CLOSE   = 3'd1,
      FUNC_INSTALL = 3'd2,
      FUNC_RD_HDL  = 3'd3,
      FUNC_WR_FLG  = 3'd4,
      FUNC_RD_FLG  = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_INVAL = 2'd1,
      ST_BADFD = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      logic            found;
      logic [IdxW-1:0] idx;
   } find_type;

endpackage

// File: rtl/core/dta_find.sv
// Next-fit free entry finder: priority encode from the hint, then from zero.
module dta_find (
   input  logic [dta_pkg::TableDepth-1:0] free_vec,
   input  logic [dta_pkg::SizeW-1:0]      size,
   input  logic [dta_pkg::HintW-1:0]      hint,
   output dta_pkg::find_type              result
);
   import dta_pkg::*;

   logic [TableDepth-1:0] cand;
   logic [TableDepth-1:0] upper;
   logic                  up_hit;
   logic [IdxW-1:0]       up_idx;
   logic                  lo_hit;
   logic [IdxW-1:0]       lo_idx;

   // mask free entries to the active range, and to the range at or past the hint
   always_comb begin
      for (int i = 0; i < TableDepth; i++) begin
         cand[i]  = free_vec[i] && (SizeW'(i) < size);
         upper[i] = cand[i] && (HintW'(i) >= hint);
      end
   end

   // pick the lowest set bit of each mask
   always_comb begin
      up_hit = 1'b0;
      up_idx = '0;
      lo_hit = 1'b0;
      lo_idx = '0;
      for (int i = TableDepth - 1; i >= 0; i--) begin
         if (upper[i]) begin
            up_hit = 1'b1;
            up_idx = IdxW'(i);
         end
         if (cand[i]) begin
            lo_hit = 1'b1;
            lo_idx = IdxW'(i);
         end
      end
   end

   // prefer the scan from the hint, fall back to the wrapped scan
   always_comb begin
      result.found = up_hit || lo_hit;
      result.idx   = up_hit ? up_idx : lo_idx;
   end

endmodule

// File: rtl/core/descriptor_table_allocator_top.sv
// Top level of the descriptor table allocator: request control, tables and result.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------------
//  request | req_func req_fd req_value req_handle    | start && !busy
//  result  | rsp_status rsp_fd_out rsp_handle_out    | rsp_valid, one cycle, no stall
//          | rsp_flags_out                           |
//  config  | csr_data (table_size)                   | csr_valid && csr_ready
//
// On each request the accept edge reads both tables, then the execute state
// searches, checks and writes back; busy is high in that state.
// The result strobe comes the cycle after execute, overlapping the next accept.
// Synchronous reset clears the per-entry handle and mark bits, the hint and the
// table size (16); the table memories need no clearing pass.
// The receiver cannot stall; csr_ready is always high.
module descriptor_table_allocator_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [2:0]                req_func,
   input  logic [7:0]                req_fd,
   input  logic [31:0]               req_value,
   input  logic [31:0]               req_handle,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_status,
   output logic [5:0]                rsp_fd_out,
   output logic [31:0]               rsp_handle_out,
   output logic [31:0]               rsp_flags_out,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [dta_pkg::SizeW-1:0] csr_data
);
   import dta_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [SizeW-1:0]      size_ff;
   logic [HintW-1:0]      hint_ff, hint_in;
   logic [TableDepth-1:0] hnz_ff, hnz_in;
   logic [TableDepth-1:0] mark_ff, mark_in;

   logic [2:0]  func_ff;
   logic [7:0]  fd_ff;
   logic [31:0] value_ff;
   logic [31:0] handle_ff;

   logic [31:0] handle_mem [TableDepth];
   logic [31:0] flag_mem   [TableDepth];
   logic [31:0] handle_rd_ff;
   logic [31:0] flag_rd_ff;

   logic            hwr_en, fwr_en;
   logic [IdxW-1:0] hwr_addr, fwr_addr;
   logic [31:0]     hwr_data, fwr_data;

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  status_ff, status_in;
   logic [5:0]  fd_out_ff, fd_out_in;
   logic [31:0] handle_out_ff, handle_out_in;
   logic [31:0] flags_out_ff, flags_out_in;

   logic                  accept;
   logic [SizeW-1:0]      act_size;
   logic                  in_range;
   logic [IdxW-1:0]       fd_idx;
   logic [TableDepth-1:0] free_vec;
   find_type              find;

   localparam logic [31:0] MarkMask = 32'(1) << ReservedBit;

   assign accept    = start && !busy;
   assign busy      = (state_ff == S_EXEC);
   assign csr_ready = 1'b1;

   // clamp the active size to the table depth
   assign act_size = (size_ff > SizeW'(TableDepth)) ? SizeW'(TableDepth) : size_ff;
   assign in_range = {1'b0, fd_ff} < 9'(act_size);
   assign fd_idx   = fd_ff[IdxW-1:0];
   assign free_vec = ~(hnz_ff | mark_ff);

   dta_find u_find (
      .free_vec (free_vec),
      .size     (act_size),
      .hint     (hint_ff),
      .result   (find)
   );

   // hold the table size register
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SizeAtReset;
      end else if (csr_valid && csr_ready) begin
         size_ff <= csr_data;
      end
   end

   // capture the request word
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff   <= req_func;
         fd_ff     <= req_fd;
         value_ff  <= req_value;
         handle_ff <= req_handle;
      end
   end

   // table memories: read at accept, write back during execute
   always_ff @(posedge clock) begin
      if (accept) begin
         handle_rd_ff <= handle_mem[req_fd[IdxW-1:0]];
         flag_rd_ff   <= flag_mem[req_fd[IdxW-1:0]];
      end
      if (hwr_en) begin
         handle_mem[hwr_addr] <= hwr_data;
      end
      if (fwr_en) begin
         flag_mem[fwr_addr] <= fwr_data;
      end
   end

   // execute one request: check, update state, form the result
   always_comb begin
      state_in      = state_ff;
      hint_in       = hint_ff;
      hnz_in        = hnz_ff;
      mark_in       = mark_ff;
      hwr_en        = 1'b0;
      hwr_addr      = fd_idx;
      hwr_data      = handle_ff;
      fwr_en        = 1'b0;
      fwr_addr      = fd_idx;
      fwr_data      = value_ff;
      rsp_valid_in  = 1'b0;
      status_in     = ST_OK;
      fd_out_in     = '0;
      handle_out_in = '0;
      flags_out_in  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            if (func_ff == FUNC_ALLOC) begin
               if (!find.found) begin
                  status_in = ST_FULL;
               end else begin
                  fwr_en            = 1'b1;
                  fwr_addr          = find.idx;
                  fwr_data          = value_ff | MarkMask;
                  hnz_in[find.idx]  = 1'b0;
                  mark_in[find.idx] = 1'b1;
                  hint_in           = HintW'(find.idx) + HintW'(1);
                  fd_out_in         = 6'(find.idx);
               end
            end else if (!in_range) begin
               status_in = ST_INVAL;
            end else begin
               priority case (func_ff)
                  FUNC_CLOSE: begin
                     fwr_en          = 1'b1;
                     mark_in[fd_idx] = 1'b0;
                     if (hnz_ff[fd_idx]) begin
                        fwr_data       = '0;
                        hnz_in[fd_idx] = 1'b0;
                        handle_out_in  = handle_rd_ff;
                        if (HintW'(fd_idx) < hint_ff) begin
                           hint_in = HintW'(fd_idx);
                        end
                     end else begin
                        fwr_data = flag_rd_ff & ~MarkMask;
                     end
                  end
                  FUNC_INSTALL: begin
                     if (handle_ff == '0) begin
                        status_in = ST_INVAL;
                     end else if (!mark_ff[fd_idx]) begin
                        status_in = ST_BADFD;
                     end else begin
                        hwr_en         = 1'b1;
                        hnz_in[fd_idx] = 1'b1;
                        fd_out_in      = 6'(fd_idx);
                     end
                  end
                  FUNC_RD_HDL: begin
                     handle_out_in = hnz_ff[fd_idx] ? handle_rd_ff : '0;
                  end
                  FUNC_WR_FLG: begin
                     if (!hnz_ff[fd_idx]) begin
                        status_in = ST_BADFD;
                     end else begin
                        fwr_en          = 1'b1;
                        mark_in[fd_idx] = value_ff[ReservedBit];
                     end
                  end
                  FUNC_RD_FLG: begin
                     flags_out_in = hnz_ff[fd_idx] ? flag_rd_ff : '0;
                  end
                  default: begin
                     status_in = ST_INVAL;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hint_ff      <= '0;
         hnz_ff       <= '0;
         mark_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hint_ff      <= hint_in;
         hnz_ff       <= hnz_in;
         mark_ff      <= mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the result word
   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      fd_out_ff     <= fd_out_in;
      handle_out_ff <= handle_out_in;
      flags_out_ff  <= flags_out_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_fd_out     = fd_out_ff;
   assign rsp_handle_out = handle_out_ff;
   assign rsp_flags_out  = flags_out_ff;

`ifndef SYNTHESIS
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted request did not enter execute");
   a_exec_one: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy && rsp_valid)
      else $error("execute did not end with a result strobe");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe during execute");
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_fd_out == '0 && rsp_handle_out == '0)
      else $error("table full result carries data");
`endif

endmodule
